// ===== design/trng_rb_pkg.sv =====
package trng_rb_pkg;

  // request kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // register offsets
  localparam logic [7:0] OFF_CR    = 8'h00;
  localparam logic [7:0] OFF_MR    = 8'h04;
  localparam logic [7:0] OFF_PKBCR = 8'h08;
  localparam logic [7:0] OFF_IER   = 8'h10;
  localparam logic [7:0] OFF_IDR   = 8'h14;
  localparam logic [7:0] OFF_IMR   = 8'h18;
  localparam logic [7:0] OFF_ISR   = 8'h1c;
  localparam logic [7:0] OFF_ODATA = 8'h50;
  localparam logic [7:0] OFF_WPMR  = 8'he4;
  localparam logic [7:0] OFF_WPSR  = 8'he8;

  localparam logic [23:0] KEY_ENABLE  = 24'h524e47;
  localparam logic [15:0] KEY_PRIVATE = 16'h524b;

  localparam logic [7:0] FULL_RATE_TICKS = 8'd84;
  localparam logic [7:0] HALF_RATE_TICKS = 8'd168;

  // interrupt status bits
  localparam int INT_DATRDY = 0;
  localparam int INT_SECE   = 1;
  localparam int INT_EOTPKB = 2;

  // protect mode bits
  localparam int PM_WPEN   = 0;
  localparam int PM_WPITEN = 1;
  localparam int PM_WPCREN = 2;
  localparam int PM_FIRSTE = 4;

  // protect status bits
  localparam int PS_WPVS   = 0;
  localparam int PS_SWE    = 3;
  localparam int PS_ECLASS = 31;

  // software error types
  localparam logic [3:0] ETYPE_RD_WO  = 4'd0;
  localparam logic [3:0] ETYPE_WR_RO  = 4'd1;
  localparam logic [3:0] ETYPE_UNDEF  = 4'd2;
  localparam logic [3:0] ETYPE_OUTPUT = 4'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  offset;
    logic [31:0] wdata;
    logic [31:0] entropy;
  } trng_rb_req_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        irq;
  } trng_rb_res_t;

  // software error capture into the protect status word
  function automatic logic [31:0] soft_err(input logic [31:0] ps, input logic [4:0] pm,
                                           input logic [7:0] off, input logic [3:0] etype,
                                           input logic err);
    logic [31:0] r;
    r = ps;
    if (!pm[PM_FIRSTE] || !r[PS_SWE]) begin
      r[PS_ECLASS] = 1'b0;
      r[27:24]     = etype;
      r[PS_SWE]    = 1'b1;
      if (!r[PS_WPVS]) r[23:8] = {8'h00, off};
      if (err) r[PS_ECLASS] = 1'b1;
    end
    return r;
  endfunction

  // write protection violation capture
  function automatic logic [31:0] protect_hit(input logic [31:0] ps, input logic [4:0] pm,
                                              input logic [7:0] off);
    logic [31:0] r;
    r = ps;
    if (!pm[PM_FIRSTE] || !r[PS_WPVS]) begin
      r[23:8]    = {8'h00, off};
      r[PS_WPVS] = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== design/trng_rb_if.sv =====
interface trng_rb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  offset;
  logic [31:0] wdata;
  logic [31:0] entropy;

  modport source (output valid, kind, offset, wdata, entropy, input ready);
  modport sink (input valid, kind, offset, wdata, entropy, output ready);
endinterface

interface trng_rb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] rdata;
  logic        irq;

  modport source (output valid, rdata, irq, input ready);
  modport sink (input valid, rdata, irq, output ready);
endinterface

// ===== design/trng_rb_core.sv =====
module trng_rb_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      fire,
  input  trng_rb_pkg::trng_rb_req_t req,
  output trng_rb_pkg::trng_rb_res_t res
);

  logic [7:0]  mode_r, mode_nxt;
  logic [2:0]  mask_r, mask_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [31:0] ow_r, ow_nxt;
  logic [4:0]  pm_r, pm_nxt;
  logic [31:0] ps_r, ps_nxt;
  logic        en_r, en_nxt;
  logic        wv_r, wv_nxt;
  logic        hp_r, hp_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic        pend_r, pend_nxt;
  logic [31:0] rdata;
  logic        blk;
  logic [31:0] raw;

  always_comb begin
    mode_nxt   = mode_r;
    mask_nxt   = mask_r;
    status_nxt = status_r;
    ow_nxt     = ow_r;
    pm_nxt     = pm_r;
    ps_nxt     = ps_r;
    en_nxt     = en_r;
    wv_nxt     = wv_r;
    hp_nxt     = hp_r;
    cnt_nxt    = cnt_r;
    pend_nxt   = pend_r;
    rdata      = '0;
    blk        = 1'b0;
    raw        = req.entropy;
    if (fire) begin
      case (req.kind)
        trng_rb_pkg::KIND_READ: begin
          case (req.offset)
            trng_rb_pkg::OFF_MR:  rdata = {24'h0, mode_r};
            trng_rb_pkg::OFF_IMR: rdata = {29'h0, mask_r};
            trng_rb_pkg::OFF_ISR: begin
              rdata      = {29'h0, status_r};
              status_nxt = '0;
            end
            trng_rb_pkg::OFF_ODATA: begin
              if (!en_r || !wv_r) begin
                ps_nxt = trng_rb_pkg::soft_err(ps_r, pm_r, req.offset,
                                               trng_rb_pkg::ETYPE_OUTPUT, 1'b1);
                status_nxt[trng_rb_pkg::INT_SECE] = 1'b1;
              end else begin
                if (!status_r[trng_rb_pkg::INT_DATRDY]) wv_nxt = 1'b0;
                rdata = ow_r;
              end
            end
            trng_rb_pkg::OFF_WPMR: rdata = {27'h0, pm_r};
            trng_rb_pkg::OFF_WPSR: begin
              rdata  = ps_r;
              ps_nxt = '0;
            end
            trng_rb_pkg::OFF_CR, trng_rb_pkg::OFF_PKBCR,
            trng_rb_pkg::OFF_IER, trng_rb_pkg::OFF_IDR: begin
              if (en_r) begin
                ps_nxt = trng_rb_pkg::soft_err(ps_r, pm_r, req.offset,
                                               trng_rb_pkg::ETYPE_RD_WO, 1'b0);
                status_nxt[trng_rb_pkg::INT_SECE] = 1'b1;
              end
            end
            default: begin
              ps_nxt = trng_rb_pkg::soft_err(ps_r, pm_r, req.offset,
                                             trng_rb_pkg::ETYPE_UNDEF, 1'b0);
              status_nxt[trng_rb_pkg::INT_SECE] = 1'b1;
            end
          endcase
        end
        trng_rb_pkg::KIND_WRITE: begin
          blk = ((req.offset == trng_rb_pkg::OFF_MR) && pm_r[trng_rb_pkg::PM_WPEN])
             || (((req.offset == trng_rb_pkg::OFF_IER) || (req.offset == trng_rb_pkg::OFF_IDR))
                 && pm_r[trng_rb_pkg::PM_WPITEN])
             || (((req.offset == trng_rb_pkg::OFF_CR) || (req.offset == trng_rb_pkg::OFF_PKBCR))
                 && pm_r[trng_rb_pkg::PM_WPCREN]);
          if (blk) begin
            ps_nxt = trng_rb_pkg::protect_hit(ps_r, pm_r, req.offset);
            status_nxt[trng_rb_pkg::INT_SECE] = 1'b1;
          end else begin
            case (req.offset)
              trng_rb_pkg::OFF_CR: begin
                if (req.wdata[31:8] == trng_rb_pkg::KEY_ENABLE && en_r != req.wdata[0]) begin
                  en_nxt = req.wdata[0];
                  if (!req.wdata[0]) begin
                    pend_nxt = 1'b0;
                    status_nxt[trng_rb_pkg::INT_DATRDY] = 1'b0;
                    wv_nxt = 1'b0;
                  end
                end
              end
              trng_rb_pkg::OFF_MR: begin
                mode_nxt = req.wdata[7:0] & 8'h81;
                // a pending countdown restarts at the new rate below
                pend_nxt = 1'b0;
              end
              trng_rb_pkg::OFF_PKBCR: begin
                if (req.wdata[31:16] == trng_rb_pkg::KEY_PRIVATE)
                  status_nxt[trng_rb_pkg::INT_EOTPKB] = 1'b1;
              end
              trng_rb_pkg::OFF_IER: mask_nxt = mask_r | req.wdata[2:0];
              trng_rb_pkg::OFF_IDR: mask_nxt = mask_r & ~req.wdata[2:0];
              trng_rb_pkg::OFF_WPMR: begin
                if (req.wdata[31:8] == trng_rb_pkg::KEY_ENABLE)
                  pm_nxt = req.wdata[4:0] & 5'h17;
              end
              trng_rb_pkg::OFF_IMR, trng_rb_pkg::OFF_ISR,
              trng_rb_pkg::OFF_ODATA, trng_rb_pkg::OFF_WPSR: begin
                if (en_r) begin
                  ps_nxt = trng_rb_pkg::soft_err(ps_r, pm_r, req.offset,
                                                 trng_rb_pkg::ETYPE_WR_RO, 1'b0);
                  status_nxt[trng_rb_pkg::INT_SECE] = 1'b1;
                end
              end
              default: begin
                ps_nxt = trng_rb_pkg::soft_err(ps_r, pm_r, req.offset,
                                               trng_rb_pkg::ETYPE_UNDEF, 1'b0);
                status_nxt[trng_rb_pkg::INT_SECE] = 1'b1;
              end
            endcase
          end
        end
        trng_rb_pkg::KIND_TICK: begin
          if (pend_r) begin
            if (cnt_r > 8'd1) begin
              cnt_nxt = cnt_r - 8'd1;
            end else begin
              cnt_nxt  = '0;
              pend_nxt = 1'b0;
              if (en_r) begin
                if (mode_r[7] && hp_r && raw == ow_r) raw[0] = ~raw[0];
                ow_nxt = raw;
                wv_nxt = 1'b1;
                hp_nxt = 1'b1;
                status_nxt[trng_rb_pkg::INT_DATRDY] = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      // enabled with no word ready always has a countdown running
      if (en_nxt && !status_nxt[trng_rb_pkg::INT_DATRDY] && !pend_nxt) begin
        pend_nxt = 1'b1;
        cnt_nxt  = mode_nxt[0] ? trng_rb_pkg::HALF_RATE_TICKS : trng_rb_pkg::FULL_RATE_TICKS;
      end
    end
  end

  assign res.rdata = rdata;
  assign res.irq   = |(status_nxt & mask_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      mask_r   <= '0;
      status_r <= '0;
      ow_r     <= '0;
      pm_r     <= '0;
      ps_r     <= '0;
      en_r     <= 1'b0;
      wv_r     <= 1'b0;
      hp_r     <= 1'b0;
      cnt_r    <= '0;
      pend_r   <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      mask_r   <= mask_nxt;
      status_r <= status_nxt;
      ow_r     <= ow_nxt;
      pm_r     <= pm_nxt;
      ps_r     <= ps_nxt;
      en_r     <= en_nxt;
      wv_r     <= wv_nxt;
      hp_r     <= hp_nxt;
      cnt_r    <= cnt_nxt;
      pend_r   <= pend_nxt;
    end
  end

`ifndef SYNTHESIS
  a_wv_needs_en: assert property (@(posedge clk) disable iff (!rst_n) wv_r |-> en_r)
    else $error("output word valid while disabled");
  a_pend_needs_en: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (en_r && !status_r[trng_rb_pkg::INT_DATRDY] && cnt_r != 8'd0))
    else $error("countdown running in a wrong state");
  a_sched_invariant: assert property (@(posedge clk) disable iff (!rst_n)
    (en_r && !status_r[trng_rb_pkg::INT_DATRDY]) |-> pend_r)
    else $error("enabled without a word or a countdown");
  a_hp_sticky: assert property (@(posedge clk) disable iff (!rst_n) hp_r |=> hp_r)
    else $error("previous-word flag dropped");
`endif

endmodule

// ===== design/trng_register_block.sv =====
// A request that is accepted is held in the request register; when it advances into
// the core, its result is written to the result register, from which it is taken.
// Throughput: one request per cycle, reads, writes and ticks alike, while results are
// taken; the request register can take a new request while the last result waits.
// Reset (rst_n low, synchronous): all core state registers, status, the countdown
// and both valid flags clear; the request and result data registers are not reset.
module trng_register_block (
  input logic          clk,
  input logic          rst_n,
  trng_rb_in_if.sink   in_chan,
  trng_rb_out_if.source out_chan
);

  logic                      s1_valid_r;
  trng_rb_pkg::trng_rb_req_t s1_req_r;
  logic                      out_valid_r;
  trng_rb_pkg::trng_rb_res_t out_res_r;
  trng_rb_pkg::trng_rb_res_t core_res;
  logic                      adv;

  assign adv           = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_req_r <= '{kind: in_chan.kind, offset: in_chan.offset,
                    wdata: in_chan.wdata, entropy: in_chan.entropy};
    end
  end

  trng_rb_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv),
    .req   (s1_req_r),
    .res   (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_res_r <= core_res;
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.rdata = out_res_r.rdata;
  assign out_chan.irq   = out_res_r.irq;

endmodule
